FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the degree counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: hw/rtl/gvdc_pkg.sv
// Package: types, codes and defaults for the vertex degree counter.
package gvdc_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned DegreeBits  = 24;

  localparam int unsigned CommandW     = 2;
  localparam int unsigned VertexW      = 10;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned VertexCountW = 11;
  localparam int unsigned DegreeValueW = 24;
  localparam int unsigned CfgIndexW    = 1;
  localparam int unsigned CfgDataW     = 11;
  localparam int unsigned InTdataW     = 24;
  localparam int unsigned OutTdataW    = 24;

  localparam logic [VertexCountW-1:0] VertexCountReset = 11'd1024;

  localparam logic [CfgIndexW-1:0] CfgDegreeMode  = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgVertexCount = 1'b1;

  typedef enum logic [CommandW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    MODE_TOTAL = 2'd0,
    MODE_IN    = 2'd1,
    MODE_OUT   = 2'd2
  } mode_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic clr_wr;
    logic wr_first;
    logic wr_second;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic is_query;
    logic edge_ok;
    logic two_writes;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/gvdc_ctrl.sv
// Controller state machine: sequences clear sweeps, edge updates and queries.
`include "assert_macros.svh"

module gvdc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gvdc_pkg::dp_status_t  status_i,
  output gvdc_pkg::ctrl_cmd_t   cmd_o
);
  import gvdc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WR_A,
    S_WR_B,
    S_QUERY
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (status_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECODE;
        end
        S_DECODE: begin
          if (status_i.is_clear)      state_q <= S_CLEAR;
          else if (status_i.edge_ok)  state_q <= S_WR_A;
          else if (status_i.is_query) state_q <= S_QUERY;
          else                        state_q <= S_IDLE;
        end
        S_WR_A: begin
          state_q <= status_i.two_writes ? S_WR_B : S_IDLE;
        end
        S_WR_B: begin
          state_q <= S_IDLE;
        end
        S_QUERY: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    cmd_o.load_item = in_valid_i && (state_q == S_IDLE);
    cmd_o.clr_wr    = (state_q == S_CLEAR);
    cmd_o.wr_first  = (state_q == S_WR_A);
    cmd_o.wr_second = (state_q == S_WR_B);
    cmd_o.load_out  = (state_q == S_QUERY) && status_i.out_free;
  end

  `ASSERT_ALWAYS(a_wr_b_after_wr_a, clk_i, rst_ni, (state_q == S_WR_B) |-> ($past(state_q) == S_WR_A))
  `ASSERT_ALWAYS(a_accept_to_decode, clk_i, rst_ni, cmd_o.load_item |=> (state_q == S_DECODE))
  `ASSERT_ALWAYS(a_query_holds, clk_i, rst_ni, ((state_q == S_QUERY) && !status_i.out_free) |=> (state_q == S_QUERY))

endmodule

FILE: hw/rtl/gvdc_datapath.sv
// Datapath: item and config registers, counter table, saturating update, result register.
`include "assert_macros.svh"

module gvdc_datapath #(
  parameter int unsigned MAX_VERTICES = gvdc_pkg::MaxVertices,
  parameter int unsigned DEGREE_BITS  = gvdc_pkg::DegreeBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gvdc_pkg::ctrl_cmd_t                 cmd_i,
  output gvdc_pkg::dp_status_t                status_o,
  input  logic [gvdc_pkg::CommandW-1:0]       command_i,
  input  logic [gvdc_pkg::VertexW-1:0]        vertex_a_i,
  input  logic [gvdc_pkg::VertexW-1:0]        vertex_b_i,
  input  logic                                undirected_i,
  input  logic                                cfg_valid_i,
  input  logic [gvdc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [gvdc_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gvdc_pkg::DegreeValueW-1:0]   degree_value_o,
  output logic                                status_flag_o
);
  import gvdc_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = ((AW + 1) > VertexCountW) ? (AW + 1) : VertexCountW;
  localparam int unsigned DB = DEGREE_BITS;

  // configuration
  logic [ModeW-1:0]        mode_q;
  logic [VertexCountW-1:0] vcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TOTAL;
      vcount_q <= VertexCountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDegreeMode:  mode_q   <= cfg_data_i[ModeW-1:0];
        CfgVertexCount: vcount_q <= cfg_data_i[VertexCountW-1:0];
        default: ;
      endcase
    end
  end

  // item held for the whole operation
  cmd_e               cmd_q;
  logic [VertexW-1:0] a_q;
  logic [VertexW-1:0] b_q;
  logic               undir_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q   <= cmd_e'(command_i);
      a_q     <= vertex_a_i;
      b_q     <= vertex_b_i;
      undir_q <= undirected_i;
    end
  end

  // decode
  logic [CW-1:0] n_eff;
  logic [CW-1:0] a_ext;
  logic [CW-1:0] b_ext;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          a_ok;
  logic          b_ok;
  logic          to_tail;
  logic          to_head;
  logic          both;
  logic          same;

  always_comb begin
    n_eff = (CW'(vcount_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);
    a_ext  = CW'(a_q);
    b_ext  = CW'(b_q);
    addr_a = a_ext[AW-1:0];
    addr_b = b_ext[AW-1:0];
    a_ok   = a_ext < n_eff;
    b_ok   = b_ext < n_eff;
    if (undir_q || (mode_q != MODE_IN && mode_q != MODE_OUT)) begin
      to_tail = 1'b1;
      to_head = 1'b1;
    end else if (mode_q == MODE_IN) begin
      to_tail = 1'b0;
      to_head = 1'b1;
    end else begin
      to_tail = 1'b1;
      to_head = 1'b0;
    end
    both = to_tail && to_head;
    same = (a_q == b_q);
  end

  // clear sweep counter
  logic [AW-1:0] cnt_q;
  logic          clr_last;

  assign clr_last = (cnt_q == AW'(MAX_VERTICES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      cnt_q <= clr_last ? '0 : cnt_q + 1'b1;
    end
  end

  // saturating update, one write port
  logic [DB-1:0] rd_a_q;
  logic [DB-1:0] rd_b_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DB-1:0] wr_base;
  logic [1:0]    wr_amount;
  logic [DB:0]   wr_sum;
  logic [DB-1:0] wr_data;

  always_comb begin
    wr_en     = cmd_i.clr_wr || cmd_i.wr_first || cmd_i.wr_second;
    wr_addr   = addr_b;
    wr_base   = rd_b_q;
    wr_amount = 2'd1;
    if (cmd_i.clr_wr) begin
      wr_addr = cnt_q;
    end else if (cmd_i.wr_first) begin
      if (both && same) begin
        wr_addr   = addr_a;
        wr_base   = rd_a_q;
        wr_amount = 2'd2;
      end else if (to_tail) begin
        wr_addr = addr_a;
        wr_base = rd_a_q;
      end
    end
    wr_sum = {1'b0, wr_base} + (DB + 1)'(wr_amount);
    if (cmd_i.clr_wr)   wr_data = '0;
    else if (wr_sum[DB]) wr_data = '1;
    else                 wr_data = wr_sum[DB-1:0];
  end

  logic [DB-1:0] mem_q [MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  // result register
  logic                    out_valid_q;
  logic [DegreeValueW-1:0] out_value_q;
  logic                    out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q  <= a_ok ? DegreeValueW'(rd_a_q) : '0;
      out_status_q <= !a_ok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign degree_value_o = out_value_q;
  assign status_flag_o  = out_status_q;

  always_comb begin
    status_o.is_clear   = (cmd_q == CMD_CLEAR);
    status_o.is_query   = (cmd_q == CMD_QUERY);
    status_o.edge_ok    = (cmd_q == CMD_EDGE) && a_ok && b_ok;
    status_o.two_writes = both && !same;
    status_o.clr_last   = clr_last;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  `ASSERT_ALWAYS(a_load_sets_valid, clk_i, rst_ni, cmd_i.load_out |=> out_valid_q)
  `ASSERT_ALWAYS(a_sweep_wraps, clk_i, rst_ni, (cmd_i.clr_wr && clr_last) |=> (cnt_q == '0))
  `ASSERT_ALWAYS(a_cnt_only_in_sweep, clk_i, rst_ni, (cnt_q != '0) |-> cmd_i.clr_wr)
  `ASSERT_NEVER(a_bad_vertex_zero, clk_i, rst_ni, out_valid_q && out_status_q && (out_value_q != '0))

endmodule

FILE: hw/rtl/graph_vertex_degree_counter.sv
// Sequence: an accepted item is decoded; an edge then writes the table once, or twice when both
// ends gain one and differ; a skipped edge or unused command returns to idle. Clear sweeps the table.
// Flow: one item at a time, single table write port; a query waits for the result slot.
// Reset: asynchronous, active low; mode 0, vertex count 1024, then a clearing sweep of all
// MAX_VERTICES entries during which no item is taken (config writes are still taken).
// Top level: vertex degree counter, stream in/out plus config write channel.
module graph_vertex_degree_counter #(
  parameter int unsigned MAX_VERTICES = gvdc_pkg::MaxVertices,
  parameter int unsigned DEGREE_BITS  = gvdc_pkg::DegreeBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] command, [11:2] vertex_a, [21:12] vertex_b, [23:22] zero
  input  logic [gvdc_pkg::InTdataW-1:0]     s_axis_tdata,
  // [0] undirected
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] degree_value
  output logic [gvdc_pkg::OutTdataW-1:0]    m_axis_tdata,
  // [0] status
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gvdc_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [gvdc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import gvdc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [CommandW-1:0] command;
  logic [VertexW-1:0]  vertex_a;
  logic [VertexW-1:0]  vertex_b;

  assign command  = s_axis_tdata[CommandW-1:0];
  assign vertex_a = s_axis_tdata[CommandW +: VertexW];
  assign vertex_b = s_axis_tdata[CommandW + VertexW +: VertexW];

  assign cfg_ready_o = 1'b1;

  gvdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gvdc_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .DEGREE_BITS  (DEGREE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_i      (command),
    .vertex_a_i     (vertex_a),
    .vertex_b_i     (vertex_b),
    .undirected_i   (s_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .degree_value_o (m_axis_tdata),
    .status_flag_o  (m_axis_tuser)
  );

endmodule
